// ===== rtl/core/lpmr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmr_pkg
// Codes, widths and controller/datapath link types of the message ring core.
// ----------------------------------------------------------------------------
package lpmr_pkg;

   localparam int HDR_BYTES = 4;
   localparam int LEN_W     = 7;

   // commands carried by a request word
   localparam logic [1:0] CMD_PUSH_BEGIN = 2'd0;
   localparam logic [1:0] CMD_PUSH_BYTE  = 2'd1;
   localparam logic [1:0] CMD_POP        = 2'd2;

   // result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_TOOLONG = 3'd2;
   localparam logic [2:0] ST_NOSPACE = 3'd3;
   localparam logic [2:0] ST_EMPTY   = 3'd4;
   localparam logic [2:0] ST_SEQ     = 3'd5;

   // source of result_length for status-only results
   localparam logic [1:0] LEN_ZERO = 2'd0;
   localparam logic [1:0] LEN_REQ  = 2'd1;
   localparam logic [1:0] LEN_PEND = 2'd2;

   typedef struct packed {
      logic             take_req;
      logic             clr_push;
      logic             arm_push;
      logic             hdr_wr;
      logic [1:0]       hdr_idx;
      logic             push_byte;
      logic             drop_inc;
      logic             set_status;
      logic [2:0]       res_status;
      logic [1:0]       res_len_sel;
      logic             emit_status;
      logic             rd_load;
      logic             rd_issue;
      logic             hdr_cap;
      logic             pop_accept;
      logic             flush;
      logic             emit_byte;
      logic             byte_last;
      logic             pop_done;
   } dp_cmd_type;

   typedef struct packed {
      logic             out_free;
      logic [1:0]       cmd;
      logic             len_zero;
      logic             len_big;
      logic             no_space;
      logic             rem_zero;
      logic             cap_zero;
      logic             fill_short;
      logic             hdr_bad;
      logic             hdr_short;
      logic             hdr_over_cap;
      logic [LEN_W-1:0] hdr_len;
   } dp_stat_type;

endpackage

// ===== rtl/core/lpmr_if.sv =====
// ----------------------------------------------------------------------------
// lpmr channel interfaces
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface lpmr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] msg_length;
   logic [7:0]  data_in;
   logic [6:0]  read_capacity;

   modport source (output valid, output cmd, output msg_length, output data_in,
                   output read_capacity, input ready);
   modport sink   (input valid, input cmd, input msg_length, input data_in,
                   input read_capacity, output ready);
endinterface

interface lpmr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [6:0]  result_length;
   logic [7:0]  data_byte;
   logic        last_of_run;
   logic [31:0] drop_total;
   logic        notify_out;

   modport source (output valid, output status, output result_length,
                   output data_byte, output last_of_run, output drop_total,
                   output notify_out, input ready);
   modport sink   (input valid, input status, input result_length,
                   input data_byte, input last_of_run, input drop_total,
                   input notify_out, output ready);
endinterface

// ===== rtl/core/lpmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpmr_ctrl
// Sequencer for push begin, push byte and pop; drives the datapath commands.
// ----------------------------------------------------------------------------
module lpmr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lpmr_pkg::dp_stat_type stat,
   output lpmr_pkg::dp_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_HDR_WR   = 3'd2;
   localparam logic [2:0] S_HDR_RD   = 3'd3;
   localparam logic [2:0] S_HDR_CHK  = 3'd4;
   localparam logic [2:0] S_POP_DATA = 3'd5;
   localparam logic [2:0] S_EMIT     = 3'd6;

   logic [2:0]                 state_ff, state_in;
   logic [2:0]                 cnt_ff, cnt_in;
   logic [lpmr_pkg::LEN_W-1:0] rd_left_ff, rd_left_in;
   logic [lpmr_pkg::LEN_W-1:0] em_left_ff, em_left_in;
   logic                       dq_valid_ff, dq_valid_in;
   logic                       emit, issue;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      rd_left_in  = rd_left_ff;
      em_left_in  = em_left_ff;
      dq_valid_in = dq_valid_ff;
      emit        = 1'b0;
      issue       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.set_status  = 1'b1;
            cmd.res_len_sel = lpmr_pkg::LEN_ZERO;
            state_in        = S_EMIT;
            case (stat.cmd)
               lpmr_pkg::CMD_PUSH_BEGIN: begin
                  cmd.clr_push = 1'b1;
                  if (stat.len_zero) begin
                     cmd.res_status = lpmr_pkg::ST_INVALID;
                  end else if (stat.len_big) begin
                     cmd.res_status = lpmr_pkg::ST_TOOLONG;
                  end else if (stat.no_space) begin
                     cmd.drop_inc   = 1'b1;
                     cmd.res_status = lpmr_pkg::ST_NOSPACE;
                  end else begin
                     cmd.arm_push    = 1'b1;
                     cmd.res_status  = lpmr_pkg::ST_OK;
                     cmd.res_len_sel = lpmr_pkg::LEN_REQ;
                     cnt_in          = '0;
                     state_in        = S_HDR_WR;
                  end
               end
               lpmr_pkg::CMD_PUSH_BYTE: begin
                  if (stat.rem_zero) begin
                     cmd.res_status = lpmr_pkg::ST_SEQ;
                  end else begin
                     cmd.push_byte   = 1'b1;
                     cmd.res_status  = lpmr_pkg::ST_OK;
                     cmd.res_len_sel = lpmr_pkg::LEN_PEND;
                  end
               end
               lpmr_pkg::CMD_POP: begin
                  if (stat.cap_zero) begin
                     cmd.res_status = lpmr_pkg::ST_INVALID;
                  end else if (stat.fill_short) begin
                     cmd.res_status = lpmr_pkg::ST_EMPTY;
                  end else begin
                     cmd.set_status = 1'b0;
                     cmd.rd_load    = 1'b1;
                     cnt_in         = '0;
                     state_in       = S_HDR_RD;
                  end
               end
               default: begin
                  cmd.res_status = lpmr_pkg::ST_INVALID;
               end
            endcase
         end
         S_HDR_WR: begin
            cmd.hdr_wr  = 1'b1;
            cmd.hdr_idx = cnt_ff[1:0];
            cnt_in      = cnt_ff + 3'd1;
            if (cnt_ff == 3'(lpmr_pkg::HDR_BYTES - 1)) begin
               state_in = S_EMIT;
            end
         end
         S_HDR_RD: begin
            // read data lands in the cycle after its address
            cmd.rd_issue = (cnt_ff != 3'(lpmr_pkg::HDR_BYTES));
            cmd.hdr_cap  = (cnt_ff != 3'd0);
            cnt_in       = cnt_ff + 3'd1;
            if (cnt_ff == 3'(lpmr_pkg::HDR_BYTES)) begin
               state_in = S_HDR_CHK;
            end
         end
         S_HDR_CHK: begin
            cmd.res_len_sel = lpmr_pkg::LEN_ZERO;
            if (stat.hdr_bad) begin
               cmd.flush      = 1'b1;
               cmd.set_status = 1'b1;
               cmd.res_status = lpmr_pkg::ST_INVALID;
               state_in       = S_EMIT;
            end else if (stat.hdr_short) begin
               cmd.set_status = 1'b1;
               cmd.res_status = lpmr_pkg::ST_EMPTY;
               state_in       = S_EMIT;
            end else if (stat.hdr_over_cap) begin
               cmd.set_status = 1'b1;
               cmd.res_status = lpmr_pkg::ST_TOOLONG;
               state_in       = S_EMIT;
            end else begin
               cmd.pop_accept = 1'b1;
               rd_left_in     = stat.hdr_len;
               em_left_in     = stat.hdr_len;
               dq_valid_in    = 1'b0;
               state_in       = S_POP_DATA;
            end
         end
         S_POP_DATA: begin
            // one read in flight, refilled as soon as its word is taken
            emit         = dq_valid_ff && stat.out_free;
            issue        = (rd_left_ff != '0) && (!dq_valid_ff || emit);
            cmd.rd_issue = issue;
            if (issue) begin
               rd_left_in = rd_left_ff - 1'b1;
            end
            dq_valid_in = issue || (dq_valid_ff && !emit);
            if (emit) begin
               cmd.emit_byte = 1'b1;
               cmd.byte_last = (em_left_ff == 7'd1);
               em_left_in    = em_left_ff - 1'b1;
               if (em_left_ff == 7'd1) begin
                  cmd.pop_done = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_status = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_ff      <= '0;
         rd_left_ff  <= '0;
         em_left_ff  <= '0;
         dq_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         rd_left_ff  <= rd_left_in;
         em_left_ff  <= em_left_in;
         dq_valid_ff <= dq_valid_in;
      end
   end

endmodule

// ===== rtl/core/lpmr_datapath.sv =====
// ----------------------------------------------------------------------------
// lpmr_datapath
// Ring memory, produce/consume counts and positions, fill, drop count,
// notify flag, push progress and the response register.
// ----------------------------------------------------------------------------
module lpmr_datapath #(
   parameter int RING_BYTES = 1024,
   parameter int MAX_MSG    = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lpmr_pkg::dp_cmd_type  cmd,
   output lpmr_pkg::dp_stat_type stat,
   input  logic [1:0]            req_cmd,
   input  logic [15:0]           req_msg_length,
   input  logic [7:0]            req_data_in,
   input  logic [6:0]            req_read_capacity,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_status,
   output logic [6:0]            rsp_result_length,
   output logic [7:0]            rsp_data_byte,
   output logic                  rsp_last_of_run,
   output logic [31:0]           rsp_drop_total,
   output logic                  rsp_notify_out
);

   localparam int PW = $clog2(RING_BYTES);
   localparam int FW = $clog2(RING_BYTES + 1);
   localparam int CW = (FW > 8) ? FW : 8;
   localparam int LW = lpmr_pkg::LEN_W;

   logic [7:0]    ring_mem [RING_BYTES];
   logic [7:0]    mem_q_ff;

   logic [1:0]    req_cmd_ff;
   logic [15:0]   req_len_ff;
   logic [7:0]    req_data_ff;
   logic [6:0]    req_cap_ff;

   logic [31:0]   prod_cnt_ff, prod_cnt_in;
   logic [PW-1:0] prod_pos_ff, prod_pos_in;
   logic [31:0]   cons_cnt_ff, cons_cnt_in;
   logic [PW-1:0] cons_pos_ff, cons_pos_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [31:0]   drop_ff, drop_in;
   logic          notify_ff, notify_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [LW-1:0] pend_ff, pend_in;

   logic [31:0]   pw_cnt_ff;
   logic [PW-1:0] pw_pos_ff;
   logic [31:0]   rd_cnt_ff;
   logic [PW-1:0] rd_pos_ff;
   logic [31:0]   pw_cnt_next, rd_cnt_next;
   logic [PW-1:0] pw_pos_next, rd_pos_next;

   logic [31:0]   hdr_ff;
   logic [2:0]    res_status_ff;
   logic [LW-1:0] res_len_ff;
   logic [LW-1:0] res_len_sel;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    out_status_ff;
   logic [LW-1:0] out_len_ff;
   logic [7:0]    out_byte_ff;
   logic          out_last_ff;
   logic [31:0]   out_drop_ff;
   logic          out_notify_ff;

   logic          wr_en;
   logic [7:0]    wr_data;
   logic [PW-1:0] mem_addr;
   logic [CW-1:0] space, need, hdr_need;
   logic [LW-1:0] len7, hdr7;
   logic          commit;

   // position follows count mod ring size, including the 32-bit wrap to zero
   function automatic logic [PW-1:0] pos_step(input logic [31:0] c,
                                              input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (c == '1 || p == PW'(RING_BYTES - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   assign pw_cnt_next = pw_cnt_ff + 32'd1;
   assign pw_pos_next = pos_step(pw_cnt_ff, pw_pos_ff);
   assign rd_cnt_next = rd_cnt_ff + 32'd1;
   assign rd_pos_next = pos_step(rd_cnt_ff, rd_pos_ff);

   assign len7     = req_len_ff[LW-1:0];
   assign hdr7     = hdr_ff[LW-1:0];
   assign space    = CW'(RING_BYTES) - CW'(fill_ff);
   assign need     = CW'(lpmr_pkg::HDR_BYTES) + CW'(len7);
   assign hdr_need = CW'(lpmr_pkg::HDR_BYTES) + CW'(hdr7);
   assign commit   = cmd.push_byte && (rem_ff == LW'(1));

   always_comb begin
      stat.out_free     = !rsp_valid_ff || rsp_ready;
      stat.cmd          = req_cmd_ff;
      stat.len_zero     = (req_len_ff == '0);
      stat.len_big      = (req_len_ff > 16'(MAX_MSG));
      stat.no_space     = (need > space);
      stat.rem_zero     = (rem_ff == '0);
      stat.cap_zero     = (req_cap_ff == '0);
      stat.fill_short   = (CW'(fill_ff) < CW'(lpmr_pkg::HDR_BYTES));
      stat.hdr_bad      = (hdr_ff == '0) || (hdr_ff > 32'(MAX_MSG));
      stat.hdr_short    = (CW'(fill_ff) < hdr_need);
      stat.hdr_over_cap = (hdr7 > req_cap_ff);
      stat.hdr_len      = hdr7;
   end

   // single port: header/payload writes and reads never share a cycle
   assign wr_en    = cmd.hdr_wr || cmd.push_byte;
   assign mem_addr = wr_en ? pw_pos_ff : rd_pos_ff;

   always_comb begin
      case (cmd.hdr_idx)
         2'd0:    wr_data = req_len_ff[7:0];
         2'd1:    wr_data = req_len_ff[15:8];
         default: wr_data = 8'd0;
      endcase
      if (cmd.push_byte) begin
         wr_data = req_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[mem_addr] <= wr_data;
      end
      if (cmd.rd_issue) begin
         mem_q_ff <= ring_mem[mem_addr];
      end
   end

   always_comb begin
      case (cmd.res_len_sel)
         lpmr_pkg::LEN_REQ:  res_len_sel = len7;
         lpmr_pkg::LEN_PEND: res_len_sel = pend_ff;
         default:            res_len_sel = '0;
      endcase
   end

   always_comb begin
      prod_cnt_in = prod_cnt_ff;
      prod_pos_in = prod_pos_ff;
      cons_cnt_in = cons_cnt_ff;
      cons_pos_in = cons_pos_ff;
      fill_in     = fill_ff;
      drop_in     = drop_ff;
      notify_in   = notify_ff;
      rem_in      = rem_ff;
      pend_in     = pend_ff;
      if (cmd.clr_push) begin
         rem_in  = '0;
         pend_in = '0;
      end
      if (cmd.arm_push) begin
         rem_in  = len7;
         pend_in = len7;
      end
      if (cmd.drop_inc) begin
         drop_in = drop_ff + 32'd1;
      end
      if (cmd.push_byte) begin
         rem_in = rem_ff - 1'b1;
      end
      if (commit) begin
         prod_cnt_in = pw_cnt_next;
         prod_pos_in = pw_pos_next;
         fill_in     = FW'(CW'(fill_ff) + CW'(lpmr_pkg::HDR_BYTES) + CW'(pend_ff));
         notify_in   = 1'b1;
      end
      if (cmd.pop_accept) begin
         fill_in = FW'(CW'(fill_ff) - hdr_need);
         if (CW'(fill_ff) == hdr_need) begin
            notify_in = 1'b0;
         end
      end
      if (cmd.flush) begin
         cons_cnt_in = prod_cnt_ff;
         cons_pos_in = prod_pos_ff;
         fill_in     = '0;
         notify_in   = 1'b0;
      end
      // every payload read has been issued, so the read pointer sits past the message
      if (cmd.pop_done) begin
         cons_cnt_in = rd_cnt_ff;
         cons_pos_in = rd_pos_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit_status || cmd.emit_byte) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_cnt_ff  <= '0;
         prod_pos_ff  <= '0;
         cons_cnt_ff  <= '0;
         cons_pos_ff  <= '0;
         fill_ff      <= '0;
         drop_ff      <= '0;
         notify_ff    <= 1'b0;
         rem_ff       <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prod_cnt_ff  <= prod_cnt_in;
         prod_pos_ff  <= prod_pos_in;
         cons_cnt_ff  <= cons_cnt_in;
         cons_pos_ff  <= cons_pos_in;
         fill_ff      <= fill_in;
         drop_ff      <= drop_in;
         notify_ff    <= notify_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         req_cmd_ff  <= req_cmd;
         req_len_ff  <= req_msg_length;
         req_data_ff <= req_data_in;
         req_cap_ff  <= req_read_capacity;
      end
      if (cmd.arm_push) begin
         pw_cnt_ff <= prod_cnt_ff;
         pw_pos_ff <= prod_pos_ff;
      end else if (wr_en) begin
         pw_cnt_ff <= pw_cnt_next;
         pw_pos_ff <= pw_pos_next;
      end
      if (cmd.rd_load) begin
         rd_cnt_ff <= cons_cnt_ff;
         rd_pos_ff <= cons_pos_ff;
      end else if (cmd.rd_issue) begin
         rd_cnt_ff <= rd_cnt_next;
         rd_pos_ff <= rd_pos_next;
      end
      // little-endian header: first byte read ends up in the low bits
      if (cmd.hdr_cap) begin
         hdr_ff <= {mem_q_ff, hdr_ff[31:8]};
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.res_status;
         res_len_ff    <= res_len_sel;
      end
      if (cmd.emit_status) begin
         out_status_ff <= res_status_ff;
         out_len_ff    <= res_len_ff;
         out_byte_ff   <= 8'd0;
         out_last_ff   <= 1'b1;
         out_drop_ff   <= drop_ff;
         out_notify_ff <= notify_ff;
      end else if (cmd.emit_byte) begin
         out_status_ff <= lpmr_pkg::ST_OK;
         out_len_ff    <= hdr7;
         out_byte_ff   <= mem_q_ff;
         out_last_ff   <= cmd.byte_last;
         out_drop_ff   <= drop_ff;
         out_notify_ff <= notify_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_result_length = out_len_ff;
   assign rsp_data_byte     = out_byte_ff;
   assign rsp_last_of_run   = out_last_ff;
   assign rsp_drop_total    = out_drop_ff;
   assign rsp_notify_out    = out_notify_ff;

endmodule

// ===== rtl/core/length_prefixed_message_ring_core.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_core
// Byte ring of length-prefixed messages with push and pop commands.
// ----------------------------------------------------------------------------
// Requests arrive on req_chan (cmd, msg_length, data_in, read_capacity) and
// results leave on rsp_chan, both valid/ready; a word moves when valid and
// ready are high at a clock edge. One request is worked on at a time.
// Push begin: decode, four header writes, result. Push byte and status-only
// results: decode, result. Pop: decode, four header reads through the single
// ring port, check, then one payload word per cycle while the receiver takes
// each word. The ring memory is single-port, so every header and payload
// byte needs its own port access.
// A stalled receiver holds the response register; the sequencer waits and
// a pop resumes its stream when the word is taken.
// Reset (synchronous, active high) clears counts, fill, drop count, notify
// and push progress; the ring contents are left as they are.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring_core #(
   parameter int RING_BYTES = 1024,
   parameter int MAX_MSG    = 64
) (
   input  logic        clock,
   input  logic        reset,
   lpmr_req_if.sink    req_chan,
   lpmr_rsp_if.source  rsp_chan
);

   lpmr_pkg::dp_cmd_type  dp_cmd;
   lpmr_pkg::dp_stat_type dp_stat;
   logic                  ready;

   assign req_chan.ready = ready;

   lpmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   lpmr_datapath #(
      .RING_BYTES (RING_BYTES),
      .MAX_MSG    (MAX_MSG)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .stat              (dp_stat),
      .req_cmd           (req_chan.cmd),
      .req_msg_length    (req_chan.msg_length),
      .req_data_in       (req_chan.data_in),
      .req_read_capacity (req_chan.read_capacity),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_status        (rsp_chan.status),
      .rsp_result_length (rsp_chan.result_length),
      .rsp_data_byte     (rsp_chan.data_byte),
      .rsp_last_of_run   (rsp_chan.last_of_run),
      .rsp_drop_total    (rsp_chan.drop_total),
      .rsp_notify_out    (rsp_chan.notify_out)
   );

endmodule

// ===== rtl/core/lpmr_checker.sv =====
// ----------------------------------------------------------------------------
// lpmr_checker
// Port-level checks of the message ring core, bound to the top level.
// ----------------------------------------------------------------------------
module lpmr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [6:0]  rsp_result_length,
   input logic [7:0]  rsp_data_byte,
   input logic        rsp_last_of_run,
   input logic [31:0] rsp_drop_total,
   input logic        rsp_notify_out
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_status,
         rsp_result_length, rsp_data_byte, rsp_last_of_run, rsp_drop_total,
         rsp_notify_out}))
      else $error("response changed while stalled");

   // one request in work at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

   // error results are single status-only words
   a_error_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lpmr_pkg::ST_OK |->
         rsp_result_length == 7'd0 && rsp_data_byte == 8'd0 && rsp_last_of_run)
      else $error("malformed error result");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind length_prefixed_message_ring_core lpmr_checker u_lpmr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_result_length (rsp_chan.result_length),
   .rsp_data_byte     (rsp_chan.data_byte),
   .rsp_last_of_run   (rsp_chan.last_of_run),
   .rsp_drop_total    (rsp_chan.drop_total),
   .rsp_notify_out    (rsp_chan.notify_out)
);

// ===== dv/tb_length_prefixed_message_ring_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_message_ring_core
// Self-checking bench for the length-prefixed message ring core. A directed
// table opens the run, a full-size message makes a round trip, and
// randomized push/pop traffic follows under four idling phases.
// Every accepted request word is run through a behavioral ring predictor and
// each response word is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_length_prefixed_message_ring_core;

   localparam int          CLK_PERIOD = 10;
   localparam int          RING_BYTES = 1024;
   localparam int          MAX_MSG    = 64;
   localparam int          N_OPENING  = 20;
   localparam int          PHASE_WORDS = 36;
   localparam logic [1:0]  CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  length;
      logic [7:0]  data;
      logic        last;
      logic [31:0] drops;
      logic        notify;
   } ring_result_type;

   // status and length typed into the table for rows that are read off directly
   typedef struct packed {
      logic        pinned;
      logic [2:0]  status;
      logic [6:0]  length;
   } word_note_type;

   typedef struct {
      logic [1:0]    cmd;
      logic [15:0]   mlen;
      logic [7:0]    din;
      logic [6:0]    cap;
      word_note_type note;
   } stim_row_type;

   localparam word_note_type NO_NOTE = '0;

   logic clock;
   logic reset;

   lpmr_req_if req_bus ();
   lpmr_rsp_if rsp_bus ();

   length_prefixed_message_ring_core #(
      .RING_BYTES (RING_BYTES),
      .MAX_MSG    (MAX_MSG)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // predictor state
   logic [7:0]   ring_mem [RING_BYTES];
   logic [31:0]  produce_cnt;
   logic [31:0]  consume_cnt;
   logic [31:0]  drop_cnt;
   logic         notify_pend;
   int unsigned  fill_left;
   int unsigned  fill_len;

   ring_result_type due_results [$];
   word_note_type   word_notes [$];

   int unsigned  idle_src_pct;
   int unsigned  stall_rsp_pct;
   int unsigned  mismatch_cnt;
   int unsigned  words_taken;
   int unsigned  results_seen;
   int unsigned  queued_msgs;

   stim_row_type opening_rows [N_OPENING] = '{
      '{lpmr_pkg::CMD_POP, 16'h0000, 8'h00, 7'd64, '{1'b1, lpmr_pkg::ST_EMPTY, 7'd0}},
      '{lpmr_pkg::CMD_PUSH_BYTE, 16'hFFFF, 8'hA5, 7'd127, '{1'b1, lpmr_pkg::ST_SEQ, 7'd0}},
      '{lpmr_pkg::CMD_PUSH_BEGIN, 16'h0000, 8'hFF, 7'd0, '{1'b1, lpmr_pkg::ST_INVALID, 7'd0}},
      '{lpmr_pkg::CMD_PUSH_BEGIN, 16'hFFFF, 8'h00, 7'd0, '{1'b1, lpmr_pkg::ST_TOOLONG, 7'd0}},
      '{lpmr_pkg::CMD_PUSH_BEGIN, 16'd65, 8'h00, 7'd0, '{1'b1, lpmr_pkg::ST_TOOLONG, 7'd0}},
      '{CMD_UNUSED, 16'h1234, 8'h5A, 7'd9, '{1'b1, lpmr_pkg::ST_INVALID, 7'd0}},
      '{lpmr_pkg::CMD_POP, 16'h0000, 8'h00, 7'd0, '{1'b1, lpmr_pkg::ST_INVALID, 7'd0}},
      '{lpmr_pkg::CMD_PUSH_BEGIN, 16'd1, 8'h00, 7'd0, '{1'b1, lpmr_pkg::ST_OK, 7'd1}},
      '{lpmr_pkg::CMD_PUSH_BYTE, 16'h0000, 8'hFF, 7'd0, '{1'b1, lpmr_pkg::ST_OK, 7'd1}},
      // begun, partly filled, then dropped by a fresh begin
      '{lpmr_pkg::CMD_PUSH_BEGIN, 16'd3, 8'h00, 7'd0, NO_NOTE},
      '{lpmr_pkg::CMD_PUSH_BYTE, 16'h0000, 8'h11, 7'd0, NO_NOTE},
      '{lpmr_pkg::CMD_PUSH_BEGIN, 16'd2, 8'h00, 7'd0, NO_NOTE},
      '{lpmr_pkg::CMD_PUSH_BYTE, 16'h0000, 8'h80, 7'd0, NO_NOTE},
      '{lpmr_pkg::CMD_PUSH_BYTE, 16'h0000, 8'h7F, 7'd0, NO_NOTE},
      '{lpmr_pkg::CMD_POP, 16'h0000, 8'h00, 7'd1, NO_NOTE},
      '{lpmr_pkg::CMD_POP, 16'h0000, 8'h00, 7'd1, '{1'b1, lpmr_pkg::ST_TOOLONG, 7'd0}},
      '{lpmr_pkg::CMD_POP, 16'h0000, 8'h00, 7'd127, NO_NOTE},
      '{lpmr_pkg::CMD_POP, 16'h0000, 8'h00, 7'd64, '{1'b1, lpmr_pkg::ST_EMPTY, 7'd0}},
      '{lpmr_pkg::CMD_PUSH_BEGIN, 16'd64, 8'h00, 7'd0, '{1'b1, lpmr_pkg::ST_OK, 7'd64}},
      '{lpmr_pkg::CMD_PUSH_BYTE, 16'h0000, 8'h00, 7'd0, '{1'b1, lpmr_pkg::ST_OK, 7'd64}}
   };

   function automatic int unsigned ring_at(input logic [31:0] count);
      return count % RING_BYTES;
   endfunction

   task automatic post_status(input logic [2:0] st, input logic [6:0] len);
      ring_result_type r;
      r.status = st;
      r.length = len;
      r.data   = 8'h00;
      r.last   = 1'b1;
      r.drops  = drop_cnt;
      r.notify = notify_pend;
      due_results.push_back(r);
   endtask

   task automatic predict_word(input logic [1:0] cmd, input logic [15:0] mlen,
                               input logic [7:0] din, input logic [6:0] cap);
      logic [31:0]     used;
      logic [31:0]     need;
      logic [31:0]     hdr;
      logic [31:0]     start;
      int unsigned     off;
      ring_result_type r;
      case (cmd)
         lpmr_pkg::CMD_PUSH_BEGIN: begin
            fill_left = 0;
            fill_len  = 0;
            used = produce_cnt - consume_cnt;
            need = lpmr_pkg::HDR_BYTES + mlen;
            if (mlen == 16'd0) begin
               post_status(lpmr_pkg::ST_INVALID, 7'd0);
            end else if (mlen > MAX_MSG) begin
               post_status(lpmr_pkg::ST_TOOLONG, 7'd0);
            end else if (used > RING_BYTES || need > RING_BYTES - used) begin
               drop_cnt++;
               post_status(lpmr_pkg::ST_NOSPACE, 7'd0);
            end else begin
               // little-endian header, upper two bytes always zero
               ring_mem[ring_at(produce_cnt)]     = mlen[7:0];
               ring_mem[ring_at(produce_cnt + 1)] = mlen[15:8];
               ring_mem[ring_at(produce_cnt + 2)] = 8'h00;
               ring_mem[ring_at(produce_cnt + 3)] = 8'h00;
               fill_left = mlen;
               fill_len  = mlen;
               post_status(lpmr_pkg::ST_OK, mlen[6:0]);
            end
         end
         lpmr_pkg::CMD_PUSH_BYTE: begin
            if (fill_left == 0) begin
               post_status(lpmr_pkg::ST_SEQ, 7'd0);
            end else begin
               off = lpmr_pkg::HDR_BYTES + fill_len - fill_left;
               ring_mem[ring_at(produce_cnt + off)] = din;
               fill_left--;
               if (fill_left == 0) begin
                  produce_cnt += lpmr_pkg::HDR_BYTES + fill_len;
                  notify_pend = 1'b1;
               end
               post_status(lpmr_pkg::ST_OK, 7'(fill_len));
            end
         end
         lpmr_pkg::CMD_POP: begin
            used = produce_cnt - consume_cnt;
            if (cap == 7'd0) begin
               post_status(lpmr_pkg::ST_INVALID, 7'd0);
            end else if (used < lpmr_pkg::HDR_BYTES) begin
               post_status(lpmr_pkg::ST_EMPTY, 7'd0);
            end else begin
               hdr = {ring_mem[ring_at(consume_cnt + 3)], ring_mem[ring_at(consume_cnt + 2)],
                      ring_mem[ring_at(consume_cnt + 1)], ring_mem[ring_at(consume_cnt)]};
               if (hdr == 32'd0 || hdr > MAX_MSG) begin
                  // corrupt header flushes whatever is queued
                  consume_cnt = produce_cnt;
                  notify_pend = 1'b0;
                  post_status(lpmr_pkg::ST_INVALID, 7'd0);
               end else if (used < lpmr_pkg::HDR_BYTES + hdr) begin
                  post_status(lpmr_pkg::ST_EMPTY, 7'd0);
               end else if (hdr > cap) begin
                  post_status(lpmr_pkg::ST_TOOLONG, 7'd0);
               end else begin
                  start = consume_cnt + lpmr_pkg::HDR_BYTES;
                  consume_cnt = start + hdr;
                  if (produce_cnt == consume_cnt) notify_pend = 1'b0;
                  for (int unsigned i = 0; i < hdr; i++) begin
                     r.status = lpmr_pkg::ST_OK;
                     r.length = hdr[6:0];
                     r.data   = ring_mem[ring_at(start + i)];
                     r.last   = (i + 1 == hdr);
                     r.drops  = drop_cnt;
                     r.notify = notify_pend;
                     due_results.push_back(r);
                  end
               end
            end
         end
         default: post_status(lpmr_pkg::ST_INVALID, 7'd0);
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_cnt++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // ------------------------------------------------------------------------
   // clock, reset, receiver
   // ------------------------------------------------------------------------
   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      rsp_bus.ready <= (stall_rsp_pct == 0) || ($urandom_range(99) >= stall_rsp_pct);
   end

   // ------------------------------------------------------------------------
   // monitor: predict on accepted requests, check accepted responses
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : word_monitor
      word_note_type   note;
      int unsigned     base;
      ring_result_type got;
      ring_result_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            note = (word_notes.size() != 0) ? word_notes.pop_front() : NO_NOTE;
            base = due_results.size();
            predict_word(req_bus.cmd, req_bus.msg_length, req_bus.data_in,
                         req_bus.read_capacity);
            if (note.pinned) begin
               due_results[base].status = note.status;
               due_results[base].length = note.length;
            end
            words_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status = rsp_bus.status;
            got.length = rsp_bus.result_length;
            got.data   = rsp_bus.data_byte;
            got.last   = rsp_bus.last_of_run;
            got.drops  = rsp_bus.drop_total;
            got.notify = rsp_bus.notify_out;
            results_seen++;
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("unexpected word st=%0d len=%0d data=%02h",
                                         got.status, got.length, got.data));
            end else begin
               want = due_results.pop_front();
               if (got !== want)
                  report_mismatch($sformatf(
                     "result %0d got st=%0d len=%0d data=%02h last=%0b drops=%0d ntf=%0b %s",
                     results_seen, got.status, got.length, got.data, got.last, got.drops,
                     got.notify, $sformatf("want st=%0d len=%0d data=%02h last=%0b drops=%0d ntf=%0b",
                     want.status, want.length, want.data, want.last, want.drops, want.notify)));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   task automatic send_word(input logic [1:0] cmd, input logic [15:0] mlen,
                            input logic [7:0] din, input logic [6:0] cap,
                            input word_note_type note);
      while (idle_src_pct != 0 && $urandom_range(99) < idle_src_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      word_notes.push_back(note);
      req_bus.valid         <= 1'b1;
      req_bus.cmd           <= cmd;
      req_bus.msg_length    <= mlen;
      req_bus.data_in       <= din;
      req_bus.read_capacity <= cap;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic push_message(input int unsigned len, input int unsigned keep);
      send_word(lpmr_pkg::CMD_PUSH_BEGIN, 16'(len), 8'($urandom), 7'($urandom), NO_NOTE);
      repeat (keep) send_word(lpmr_pkg::CMD_PUSH_BYTE, 16'($urandom), 8'($urandom),
                              7'($urandom), NO_NOTE);
   endtask

   task automatic pop_message(input logic [6:0] cap);
      send_word(lpmr_pkg::CMD_POP, 16'($urandom), 8'($urandom), cap, NO_NOTE);
      if (queued_msgs != 0 && cap >= MAX_MSG) queued_msgs--;
   endtask

   // one full-size message in and out, then a pop of the drained ring
   task automatic full_size_round();
      push_message(MAX_MSG, MAX_MSG);
      repeat (2) pop_message(7'(MAX_MSG));
      queued_msgs = 0;
   endtask

   task automatic random_traffic(input int unsigned n_words);
      int unsigned sent_here;
      int unsigned pick;
      int unsigned len;
      int unsigned keep;
      logic [6:0]  cap;
      sent_here = 0;
      while (sent_here < n_words) begin
         pick = $urandom_range(99);
         if (queued_msgs > 3) pick = 60;
         if (pick < 55) begin
            len  = ($urandom_range(7) == 0) ? $urandom_range(MAX_MSG, 1) : $urandom_range(8, 1);
            keep = ($urandom_range(9) == 0) ? $urandom_range(len - 1, 0) : len;
            push_message(len, keep);
            sent_here += keep + 1;
            if (keep == len) queued_msgs++;
         end else if (pick < 85) begin
            case ($urandom_range(9))
               0:       cap = 7'($urandom_range(127, 0));
               1, 2:    cap = 7'($urandom_range(127, 1));
               default: cap = 7'(MAX_MSG);
            endcase
            pop_message(cap);
            sent_here++;
         end else begin
            case ($urandom_range(3))
               0: send_word(CMD_UNUSED, 16'($urandom), 8'($urandom), 7'($urandom), NO_NOTE);
               1: send_word(lpmr_pkg::CMD_PUSH_BEGIN, 16'($urandom), 8'($urandom),
                            7'($urandom), NO_NOTE);
               2: send_word(lpmr_pkg::CMD_PUSH_BYTE, 16'($urandom), 8'($urandom),
                            7'($urandom), NO_NOTE);
               default: send_word(lpmr_pkg::CMD_PUSH_BEGIN,
                                  16'($urandom_range(1, 0) ? 0 : 65),
                                  8'($urandom), 7'($urandom), NO_NOTE);
            endcase
            sent_here++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      int unsigned drain_wait;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.cmd           = lpmr_pkg::CMD_PUSH_BEGIN;
      req_bus.msg_length    = 16'h0000;
      req_bus.data_in       = 8'h00;
      req_bus.read_capacity = 7'd0;
      rsp_bus.ready         = 1'b0;
      idle_src_pct          = 0;
      stall_rsp_pct         = 0;
      mismatch_cnt          = 0;
      words_taken           = 0;
      results_seen          = 0;
      queued_msgs           = 0;
      produce_cnt           = '0;
      consume_cnt           = '0;
      drop_cnt              = '0;
      notify_pend           = 1'b0;
      fill_left             = 0;
      fill_len              = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening_rows[i])
         send_word(opening_rows[i].cmd, opening_rows[i].mlen, opening_rows[i].din,
                   opening_rows[i].cap, opening_rows[i].note);

      full_size_round();

      random_traffic(PHASE_WORDS);
      idle_src_pct = 77;
      random_traffic(PHASE_WORDS);
      idle_src_pct  = 0;
      stall_rsp_pct = 77;
      random_traffic(PHASE_WORDS);
      idle_src_pct  = 19;
      stall_rsp_pct = 19;
      random_traffic(PHASE_WORDS);
      req_bus.valid <= 1'b0;

      drain_wait = 0;
      while (due_results.size() != 0 && drain_wait < 20000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (100) @(posedge clock);
      if (due_results.size() != 0)
         report_mismatch($sformatf("%0d result words never arrived", due_results.size()));

      $display("covered %0d request words and %0d result words across four idling phases",
               words_taken, results_seen);
      $display("error rows, a full-size round trip and random push/pop; produce count %0d",
               produce_cnt);
      if (mismatch_cnt == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout waiting for the ring to finish");
      $display("end of test: mismatches");
      $finish;
   end

endmodule
